[sv/ray_sphere_reflect_unit_assert.svh]
// ----------------------------------------------------------------------------
// ray_sphere_reflect_unit_assert.svh
// Assertion macros for the ray/sphere reflect unit. Define ASSERT_OFF to drop.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_REFLECT_UNIT_ASSERT_SVH
`define RAY_SPHERE_REFLECT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsr assertion failed");
// next-cycle implication
`define RSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsr assertion failed");
`else
`define RSR_ASSERT_IMP(lbl, ante, cons)
`define RSR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[sv/rsr_pkg.sv]
// ----------------------------------------------------------------------------
// rsr_pkg
// Beat types, latency helpers and saturation for the ray/sphere reflect unit.
// ----------------------------------------------------------------------------
package rsr_pkg;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic        [30:0] sphere_radius;
  } rsr_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] refl_x;
    logic signed [31:0] refl_y;
    logic signed [31:0] refl_z;
  } rsr_out_t;

  localparam int LimbW = 32;
  localparam logic signed [39:0] SatHi = 40'sd2147483647;
  localparam logic signed [39:0] SatLo = -40'sd2147483648;
  localparam logic signed [31:0] Max32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Min32 = 32'sh8000_0000;

  // latency of rsr_mul: one limb product per stage plus entry and exit registers
  function automatic int mul_lat(int aw, int bw);
    return ((aw + LimbW - 1) / LimbW) * ((bw + LimbW - 1) / LimbW) + 2;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > SatHi) r = Max32;
    else if (x < SatLo) r = Min32;
    else r = x[31:0];
    return r;
  endfunction

endpackage

[sv/rsr_if.sv]
// ----------------------------------------------------------------------------
// rsr_if
// Valid/ready channels for ray beats in and result beats out.
// ----------------------------------------------------------------------------
interface rsr_in_if;
  logic             valid;
  logic             ready;
  rsr_pkg::rsr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rsr_out_if;
  logic              valid;
  logic              ready;
  rsr_pkg::rsr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/ray_sphere_reflect_unit.sv]
// One beat per cycle sustained while each result beat is taken.
// Depth is set by the 64-stage square root and the two 35/33-stage dividers.
// The whole pipeline advances together; it holds when the output beat is not taken.
// Reset (rst_ni low, async) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// ray_sphere_reflect_unit
// Ray/sphere far-root intersection and specular reflection, fully pipelined.
// ----------------------------------------------------------------------------
`include "ray_sphere_reflect_unit_assert.svh"

module ray_sphere_reflect_unit (
  input logic        clk_i,
  input logic        rst_ni,
  rsr_in_if.sink     in_i,
  rsr_out_if.source  out_o
);
  import rsr_pkg::*;

  localparam int SqW = 128;
  localparam int Qb1 = 35;
  localparam int Qb2 = 33;
  localparam int L1  = mul_lat(33, 33);
  localparam int L2  = mul_lat(68, 68);
  localparam int LS  = SqW / 2 + 1;
  localparam int L3  = mul_lat(69, 32);
  localparam int LD1 = Qb1 + 2;
  localparam int L4  = mul_lat(37, 32);
  localparam int L5  = mul_lat(72, 37);
  localparam int LD2 = Qb2 + 2;

  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][32:0] dl;
    logic [2:0][31:0] c;
    logic [30:0]      r;
    logic [63:0]      a;
    logic [67:0]      bh;
    logic [61:0]      r2;
    logic [2:0][36:0] e;
    logic [2:0][31:0] hp;
    logic             nohit;
  } pl_t;

  localparam int PlW = $bits(pl_t);

  logic en;
  logic out_valid_q;
  rsr_out_t out_q, out_d;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // ---- stage 0: input register
  rsr_in_t s0_q;
  logic    v0_q;

  // ---- stage 1: offsets from centre
  pl_t  p1_d, p1_q;
  logic v1_q;

  always_comb begin
    p1_d       = '0;
    p1_d.d[0]  = s0_q.dir_x;
    p1_d.d[1]  = s0_q.dir_y;
    p1_d.d[2]  = s0_q.dir_z;
    p1_d.c[0]  = s0_q.centre_x;
    p1_d.c[1]  = s0_q.centre_y;
    p1_d.c[2]  = s0_q.centre_z;
    p1_d.r     = s0_q.sphere_radius;
    p1_d.dl[0] = 33'(s0_q.start_x) - 33'(s0_q.centre_x);
    p1_d.dl[1] = 33'(s0_q.start_y) - 33'(s0_q.centre_y);
    p1_d.dl[2] = 33'(s0_q.start_z) - 33'(s0_q.centre_z);
  end

  // ---- dot products
  logic signed [65:0] dd_w [3];
  logic signed [65:0] db_w [3];
  logic signed [65:0] ll_w [3];
  logic signed [65:0] rr_w;

  for (genvar i = 0; i < 3; i++) begin : g_m1
    rsr_mul #(.AW(33), .BW(33)) u_dd (
      .clk_i, .en_i(en),
      .a_i(33'(signed'(p1_q.d[i]))), .b_i(33'(signed'(p1_q.d[i]))), .p_o(dd_w[i])
    );
    rsr_mul #(.AW(33), .BW(33)) u_db (
      .clk_i, .en_i(en),
      .a_i(33'(signed'(p1_q.d[i]))), .b_i(signed'(p1_q.dl[i])), .p_o(db_w[i])
    );
    rsr_mul #(.AW(33), .BW(33)) u_ll (
      .clk_i, .en_i(en),
      .a_i(signed'(p1_q.dl[i])), .b_i(signed'(p1_q.dl[i])), .p_o(ll_w[i])
    );
  end

  rsr_mul #(.AW(33), .BW(33)) u_rr (
    .clk_i, .en_i(en),
    .a_i(signed'({2'b00, p1_q.r})), .b_i(signed'({2'b00, p1_q.r})), .p_o(rr_w)
  );

  pl_t  p1d;
  logic v1d;
  rsr_delay #(.W(PlW), .L(L1)) u_d1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .data_i(p1_q), .valid_o(v1d), .data_o(p1d)
  );

  // ---- stage 2: quadratic coefficients
  logic signed [67:0] a2, bh2, c2, c2_q;
  pl_t  p2_d, p2_q;
  logic v2_q;

  always_comb begin
    a2   = 68'(dd_w[0]) + 68'(dd_w[1]) + 68'(dd_w[2]);
    bh2  = 68'(db_w[0]) + 68'(db_w[1]) + 68'(db_w[2]);
    c2   = 68'(ll_w[0]) + 68'(ll_w[1]) + 68'(ll_w[2]) - 68'(rr_w);
    p2_d       = p1d;
    p2_d.a     = a2[63:0];
    p2_d.bh    = bh2;
    p2_d.r2    = rr_w[61:0];
    p2_d.nohit = (a2 == '0) || (p1d.r == '0);
  end

  logic signed [135:0] bb_w, ac_w;
  rsr_mul #(.AW(68), .BW(68)) u_bb (
    .clk_i, .en_i(en), .a_i(signed'(p2_q.bh)), .b_i(signed'(p2_q.bh)), .p_o(bb_w)
  );
  rsr_mul #(.AW(68), .BW(68)) u_ac (
    .clk_i, .en_i(en), .a_i(signed'(68'(p2_q.a))), .b_i(c2_q), .p_o(ac_w)
  );

  pl_t  p2d;
  logic v2d;
  rsr_delay #(.W(PlW), .L(L2)) u_d2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .data_i(p2_q), .valid_o(v2d), .data_o(p2d)
  );

  // ---- stage 3: discriminant
  logic signed [136:0] disc;
  logic [SqW-1:0] rad_d, rad_q;
  pl_t  p3_d, p3_q;
  logic v3_q;

  always_comb begin
    disc       = 137'(bb_w) - 137'(ac_w);
    p3_d       = p2d;
    p3_d.nohit = p2d.nohit || disc[136];
    // nonnegative disc is bounded by a*R^2 < 2^127
    rad_d      = p3_d.nohit ? '0 : disc[SqW-1:0];
  end

  logic [SqW/2-1:0] s_w;
  rsr_sqrt #(.RW(SqW)) u_sqrt (.clk_i, .en_i(en), .rad_i(rad_q), .root_o(s_w));

  pl_t  p3d;
  logic v3d;
  rsr_delay #(.W(PlW), .L(LS)) u_d3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .data_i(p3_q), .valid_o(v3d), .data_o(p3d)
  );

  // ---- stage 4: N = s - bh, then N*D/a
  logic signed [68:0] n_d, n_q;
  pl_t  p4_q;
  logic v4_q;

  assign n_d = signed'(69'(s_w)) - 69'(signed'(p3d.bh));

  logic signed [100:0] nd_w [3];
  for (genvar i = 0; i < 3; i++) begin : g_m3
    rsr_mul #(.AW(69), .BW(32)) u_nd (
      .clk_i, .en_i(en), .a_i(n_q), .b_i(signed'(p4_q.d[i])), .p_o(nd_w[i])
    );
  end

  pl_t  p4d;
  logic v4d;
  rsr_delay #(.W(PlW), .L(L3)) u_d4 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .data_i(p4_q), .valid_o(v4d), .data_o(p4d)
  );

  // quotient magnitude stays below R + |delta| < 2^34
  logic signed [Qb1:0] q1_w [3];
  for (genvar i = 0; i < 3; i++) begin : g_dv1
    rsr_div #(.NW(101), .DW(64), .QB(Qb1)) u_div (
      .clk_i, .en_i(en), .num_i(nd_w[i]),
      .den_i(p4d.nohit ? 64'd1 : p4d.a),
      .quo_o(q1_w[i]), .ovf_o(), .neg_o()
    );
  end

  pl_t  p4dd;
  logic v4dd;
  rsr_delay #(.W(PlW), .L(LD1)) u_d5 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4d), .data_i(p4d), .valid_o(v4dd), .data_o(p4dd)
  );

  // ---- stage 5: hit point relative to centre
  pl_t  p5_d, p5_q;
  logic v5_q;

  always_comb begin
    logic signed [36:0] ev;
    p5_d = p4dd;
    for (int i = 0; i < 3; i++) begin
      ev          = 37'(signed'(p4dd.dl[i])) + 37'(q1_w[i]);
      p5_d.e[i]   = ev;
      p5_d.hp[i]  = sat32(40'(signed'(p4dd.c[i])) + 40'(ev));
    end
  end

  logic signed [68:0] ed_w [3];
  for (genvar i = 0; i < 3; i++) begin : g_m4
    rsr_mul #(.AW(37), .BW(32)) u_ed (
      .clk_i, .en_i(en), .a_i(signed'(p5_q.e[i])), .b_i(signed'(p5_q.d[i])), .p_o(ed_w[i])
    );
  end

  pl_t  p5d;
  logic v5d;
  rsr_delay #(.W(PlW), .L(L4)) u_d6 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .data_i(p5_q), .valid_o(v5d), .data_o(p5d)
  );

  // ---- stage 6: 2k = 2 e.D, then 2k*e / R^2
  logic signed [70:0] k_w;
  logic signed [71:0] k2_q;
  pl_t  p6_q;
  logic v6_q;

  assign k_w = 71'(ed_w[0]) + 71'(ed_w[1]) + 71'(ed_w[2]);

  logic signed [108:0] ke_w [3];
  for (genvar i = 0; i < 3; i++) begin : g_m5
    rsr_mul #(.AW(72), .BW(37)) u_ke (
      .clk_i, .en_i(en), .a_i(k2_q), .b_i(signed'(p6_q.e[i])), .p_o(ke_w[i])
    );
  end

  pl_t  p6d;
  logic v6d;
  rsr_delay #(.W(PlW), .L(L5)) u_d7 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .data_i(p6_q), .valid_o(v6d), .data_o(p6d)
  );

  logic signed [Qb2:0] q2_w [3];
  logic [2:0] ovf2_w, neg2_w;
  for (genvar i = 0; i < 3; i++) begin : g_dv2
    rsr_div #(.NW(109), .DW(62), .QB(Qb2)) u_div (
      .clk_i, .en_i(en), .num_i(ke_w[i]),
      .den_i(p6d.nohit ? 62'd1 : p6d.r2),
      .quo_o(q2_w[i]), .ovf_o(ovf2_w[i]), .neg_o(neg2_w[i])
    );
  end

  pl_t  p7d;
  logic v7d;
  rsr_delay #(.W(PlW), .L(LD2)) u_d8 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6d), .data_i(p6d), .valid_o(v7d), .data_o(p7d)
  );

  // ---- output stage
  always_comb begin
    logic signed [31:0] rv [3];
    for (int i = 0; i < 3; i++) begin
      // a quotient of 2^33 or more always saturates against a 32-bit D
      if (ovf2_w[i]) rv[i] = neg2_w[i] ? Max32 : Min32;
      else rv[i] = sat32(40'(signed'(p7d.d[i])) - 40'(q2_w[i]));
    end
    out_d = '0;
    if (!p7d.nohit) begin
      out_d.hit    = 1'b1;
      out_d.hit_x  = p7d.hp[0];
      out_d.hit_y  = p7d.hp[1];
      out_d.hit_z  = p7d.hp[2];
      out_d.refl_x = rv[0];
      out_d.refl_y = rv[1];
      out_d.refl_z = rv[2];
    end
  end

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= in_i.valid;
      v1_q        <= v0_q;
      v2_q        <= v1d;
      v3_q        <= v2d;
      v4_q        <= v3d;
      v5_q        <= v4dd;
      v6_q        <= v5d;
      out_valid_q <= v7d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q  <= in_i.data;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      c2_q  <= c2;
      p3_q  <= p3_d;
      rad_q <= rad_d;
      p4_q  <= p3d;
      n_q   <= n_d;
      p5_q  <= p5_d;
      p6_q  <= p5d;
      k2_q  <= {k_w, 1'b0};
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---- checks
  `RSR_ASSERT_NXT(a_accept_enters, in_i.valid && in_i.ready, v0_q)
  `RSR_ASSERT_NXT(a_stall_freezes, !en, $stable(v0_q) && $stable(v6_q))
  `RSR_ASSERT_IMP(a_miss_is_zero, out_o.valid && !out_o.data.hit, out_o.data.hit_x == 32'sd0 && out_o.data.refl_x == 32'sd0)
endmodule

[sv/rsr_delay.sv]
// ----------------------------------------------------------------------------
// rsr_delay
// Side-band shift line: carries payload and its valid bit alongside a unit.
// ----------------------------------------------------------------------------
module rsr_delay #(
  parameter int W = 8,
  parameter int L = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  logic [L-1:0] vld_q;
  logic [W-1:0] dat_q [L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      for (int k = L - 1; k > 0; k--) vld_q[k] <= vld_q[k-1];
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = L - 1; k > 0; k--) dat_q[k] <= dat_q[k-1];
      dat_q[0] <= data_i;
    end
  end

  assign valid_o = vld_q[L-1];
  assign data_o  = dat_q[L-1];
endmodule

[sv/rsr_mul.sv]
// ----------------------------------------------------------------------------
// rsr_mul
// Pipelined signed multiplier: one 32x32 limb product accumulated per stage.
// ----------------------------------------------------------------------------
module rsr_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import rsr_pkg::*;

  localparam int NA = (AW + LimbW - 1) / LimbW;
  localparam int NB = (BW + LimbW - 1) / LimbW;
  localparam int NS = NA * NB;
  localparam int PW = AW + BW;

  logic [AW-1:0]       abs_a;
  logic [BW-1:0]       abs_b;
  logic [NA*LimbW-1:0] ma_q  [NS+1];
  logic [NB*LimbW-1:0] mb_q  [NS+1];
  logic                neg_q [NS+1];
  logic [PW-1:0]       acc_q [NS+1];
  logic [PW-1:0]       p_q;

  assign abs_a = a_i[AW-1] ? AW'(~a_i) + AW'(1) : AW'(a_i);
  assign abs_b = b_i[BW-1] ? BW'(~b_i) + BW'(1) : BW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q[0]  <= (NA*LimbW)'(abs_a);
      mb_q[0]  <= (NB*LimbW)'(abs_b);
      neg_q[0] <= a_i[AW-1] ^ b_i[BW-1];
      acc_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int I = k / NB;
    localparam int J = k % NB;
    logic [2*LimbW-1:0] pp;
    logic [PW-1:0]      sh;
    assign pp = ma_q[k][I*LimbW +: LimbW] * mb_q[k][J*LimbW +: LimbW];
    assign sh = PW'(pp) << (LimbW * (I + J));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k+1] <= acc_q[k] + sh;
        ma_q[k+1]  <= ma_q[k];
        mb_q[k+1]  <= mb_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= neg_q[NS] ? ~acc_q[NS] + PW'(1) : acc_q[NS];
  end

  assign p_o = signed'(p_q);
endmodule

[sv/rsr_sqrt.sv]
// ----------------------------------------------------------------------------
// rsr_sqrt
// Pipelined floor square root, one root bit per stage (restoring).
// ----------------------------------------------------------------------------
module rsr_sqrt #(
  parameter int RW = 128
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RW-1:0]   rad_i,
  output logic [RW/2-1:0] root_o
);
  localparam int R = RW / 2;

  logic [R+1:0]  rem_q  [R+1];
  logic [R-1:0]  root_q [R+1];
  logic [RW-1:0] rad_q  [R+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= rad_i;
    end
  end

  for (genvar k = 0; k < R; k++) begin : g_step
    logic [R+1:0] sh;
    logic [R+1:0] tr;
    logic         ge;
    // bring down the next two radicand bits, try root*4+1
    assign sh = {rem_q[k][R-1:0], rad_q[k][RW-1 -: 2]};
    assign tr = {root_q[k], 2'b01};
    assign ge = sh >= tr;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? sh - tr : sh;
        root_q[k+1] <= {root_q[k][R-2:0], ge};
        rad_q[k+1]  <= rad_q[k] << 2;
      end
    end
  end

  assign root_o = root_q[R];
endmodule

[sv/rsr_div.sv]
// ----------------------------------------------------------------------------
// rsr_div
// Pipelined signed-by-unsigned divider, truncating, one quotient bit a stage.
// Quotients of more than QB bits are flagged instead of computed.
// ----------------------------------------------------------------------------
module rsr_div #(
  parameter int NW = 101,
  parameter int DW = 64,
  parameter int QB = 35
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic        [DW-1:0] den_i,
  output logic signed [QB:0]   quo_o,
  output logic                 ovf_o,
  output logic                 neg_o
);
  logic [NW-1:0]    mag;
  logic [NW-QB-1:0] hi;
  logic [DW-1:0]    rem_q [QB+1];
  logic [QB-1:0]    lo_q  [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic [DW-1:0]    den_q [QB+1];
  logic             neg_q [QB+1];
  logic             ovf_q [QB+1];
  logic [QB:0]      res_q;
  logic             ovf_out_q;
  logic             neg_out_q;

  assign mag = num_i[NW-1] ? NW'(~num_i) + NW'(1) : NW'(num_i);
  assign hi  = mag[NW-1:QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(hi);
      lo_q[0]  <= mag[QB-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= num_i[NW-1];
      ovf_q[0] <= hi >= (NW-QB)'(den_i);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] sh;
    logic        ge;
    assign sh = {rem_q[k], lo_q[k][QB-1]};
    assign ge = sh >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? DW'(sh - {1'b0, den_q[k]}) : DW'(sh);
        lo_q[k+1]  <= lo_q[k] << 1;
        quo_q[k+1] <= {quo_q[k][QB-2:0], ge};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q     <= neg_q[QB] ? ~{1'b0, quo_q[QB]} + (QB+1)'(1) : {1'b0, quo_q[QB]};
      ovf_out_q <= ovf_q[QB];
      neg_out_q <= neg_q[QB];
    end
  end

  assign quo_o = signed'(res_q);
  assign ovf_o = ovf_out_q;
  assign neg_o = neg_out_q;
endmodule

[tb/tb_ray_sphere_reflect_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_reflect_unit
// Drives ray beats into the reflect unit under changing backpressure, checks
// each beat against a typed want or an exact wide-integer ray/sphere predictor.
// ----------------------------------------------------------------------------
module tb_ray_sphere_reflect_unit;
  import rsr_pkg::*;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    rsr_in_t  ray;
    bit       typed;
    rsr_out_t want;
  } ray_row_t;

  localparam wide_t WideMax = 192'sd2147483647;
  localparam wide_t WideMin = -192'sd2147483648;
  localparam int    HoldCycles = 400;
  localparam int    StallLimit = 20000;
  localparam int    DrainCycles = 250;

  logic clk_i;
  logic rst_ni;

  rsr_in_if  in_ch();
  rsr_out_if out_ch();

  ray_sphere_reflect_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rsr_out_t reflect_q[$];
  int       err_cnt;
  int       send_idle;
  int       recv_idle;
  bit       hold_req;
  int       hold_left;
  int       stall_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // predictor
  function automatic wide_t floor_sqrt(wide_t n);
    logic [191:0] r, t, un;
    un = n;
    r = '0;
    for (int k = 95; k >= 0; k--) begin
      t = r;
      t[k] = 1'b1;
      if (t * t <= un) r = t;
    end
    return wide_t'(r);
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t x);
    if (x > WideMax) return Max32;
    if (x < WideMin) return Min32;
    return x[31:0];
  endfunction

  function automatic rsr_out_t reflect_ray(rsr_in_t ray);
    wide_t d[3], dl[3], cc[3], e[3];
    wide_t a, bh, c, r2, disc, nn, k, u;
    logic signed [31:0] p[3], dv[3], cv[3];
    rsr_out_t res;
    p  = '{ray.start_x, ray.start_y, ray.start_z};
    dv = '{ray.dir_x, ray.dir_y, ray.dir_z};
    cv = '{ray.centre_x, ray.centre_y, ray.centre_z};
    res = '0;
    a = 0; bh = 0; c = 0; k = 0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = wide_t'(dv[i]);
      cc[i] = wide_t'(cv[i]);
      dl[i] = wide_t'(p[i]) - cc[i];
      a  += d[i] * d[i];
      bh += d[i] * dl[i];
      c  += dl[i] * dl[i];
    end
    r2 = wide_t'({161'b0, ray.sphere_radius}) * wide_t'({161'b0, ray.sphere_radius});
    c -= r2;
    if (a == 0 || ray.sphere_radius == 0) return res;
    disc = bh * bh - a * c;
    if (disc < 0) return res;
    nn = floor_sqrt(disc) - bh;
    for (int i = 0; i < 3; i++) begin
      e[i] = dl[i] + (nn * d[i]) / a;
      k += e[i] * d[i];
    end
    res.hit = 1'b1;
    res.hit_x = clamp32(cc[0] + e[0]);
    res.hit_y = clamp32(cc[1] + e[1]);
    res.hit_z = clamp32(cc[2] + e[2]);
    u = (k + k) * e[0]; res.refl_x = clamp32(d[0] - u / r2);
    u = (k + k) * e[1]; res.refl_y = clamp32(d[1] - u / r2);
    u = (k + k) * e[2]; res.refl_z = clamp32(d[2] - u / r2);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  function automatic rsr_in_t mk_ray(int sx, int sy, int sz, int dx, int dy, int dz,
                                     int cx, int cy, int cz, int unsigned rad);
    rsr_in_t r;
    r.start_x = sx; r.start_y = sy; r.start_z = sz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.centre_x = cx; r.centre_y = cy; r.centre_z = cz;
    r.sphere_radius = rad[30:0];
    return r;
  endfunction

  function automatic rsr_in_t random_ray();
    rsr_in_t r;
    int unsigned kind;
    int cx, cy, cz, rad;
    kind = $urandom_range(9);
    r.dir_x = $urandom; r.dir_y = $urandom; r.dir_z = $urandom;
    if (kind < 2) begin
      // raw noise over the full field ranges
      r.start_x = $urandom; r.start_y = $urandom; r.start_z = $urandom;
      r.centre_x = $urandom; r.centre_y = $urandom; r.centre_z = $urandom;
      r.sphere_radius = 31'($urandom_range(32'h7FFF_FFFF, 1));
      return r;
    end
    if ($urandom_range(3) == 0) r.dir_x = $signed($urandom) >>> $urandom_range(30);
    cx = $signed($urandom) >>> 9;
    cy = $signed($urandom) >>> 9;
    cz = $signed($urandom) >>> 9;
    rad = (kind == 2) ? $urandom_range(32'h0100_0000, 1) : $urandom_range(1 << 20, 1);
    r.centre_x = cx; r.centre_y = cy; r.centre_z = cz;
    r.sphere_radius = rad[30:0];
    // start roughly inside or just outside the sphere
    r.start_x = cx + $signed($urandom_range(2 * rad)) - rad;
    r.start_y = cy + $signed($urandom_range(2 * rad)) - rad;
    r.start_z = cz + $signed($urandom_range(2 * rad)) - rad;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, field, got, want);
    err_cnt++;
  endtask

  task automatic send_ray(rsr_in_t ray, bit typed, rsr_out_t want);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ray;
    do @(posedge clk_i); while (!in_ch.ready);
    reflect_q.push_back(typed ? want : reflect_ray(ray));
    @(negedge clk_i);
  endtask

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (reflect_q.size() == 0) begin
        report_mismatch("beat with nothing pending", 32'(out_ch.data.hit), 32'd0);
      end else begin
        rsr_out_t got, want;
        got = out_ch.data;
        want = reflect_q.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.hit_x !== want.hit_x) report_mismatch("hit_x", got.hit_x, want.hit_x);
        if (got.hit_y !== want.hit_y) report_mismatch("hit_y", got.hit_y, want.hit_y);
        if (got.hit_z !== want.hit_z) report_mismatch("hit_z", got.hit_z, want.hit_z);
        if (got.refl_x !== want.refl_x) report_mismatch("refl_x", got.refl_x, want.refl_x);
        if (got.refl_y !== want.refl_y) report_mismatch("refl_y", got.refl_y, want.refl_y);
        if (got.refl_z !== want.refl_z) report_mismatch("refl_z", got.refl_z, want.refl_z);
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("tb_ray_sphere_reflect_unit: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  initial begin
    ray_row_t rows[$];
    ray_row_t row;
    rsr_out_t none;
    none = '0;
    err_cnt = 0; stall_cnt = 0; hold_left = 0; hold_req = 1'b0;
    send_idle = 6; recv_idle = 52;
    in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero direction and miss: blank result
    row = '{mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 1024), 1, none}; rows.push_back(row);
    row = '{mk_ray(10000, 0, 0, 0, 1 << 24, 0, 0, 0, 0, 100), 1, none}; rows.push_back(row);
    // zero radius: no normal
    row = '{mk_ray(5, 5, 5, 1 << 24, 0, 0, 0, 0, 0, 0), 1, none}; rows.push_back(row);
    // sphere of radius 1024 head-on from centre: bounces straight back
    row.ray = mk_ray(0, 0, 0, 1 << 24, 0, 0, 0, 0, 0, 1024);
    row.typed = 1;
    row.want = '{1'b1, 32'sd1024, 32'sd0, 32'sd0, -32'sd16777216, 32'sd0, 32'sd0};
    rows.push_back(row);
    // far root from a start point outside and from one inside the sphere
    row = '{mk_ray(-5000, 0, 0, 1 << 24, 0, 0, 0, 0, 0, 1024), 0, none}; rows.push_back(row);
    row = '{mk_ray(300, -200, 100, -3 << 20, 1 << 22, 7, 0, 0, 0, 2048), 0, none};
    rows.push_back(row);
    // field extremes and saturation
    row = '{mk_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
            0, none}; rows.push_back(row);
    row = '{mk_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF),
            0, none}; rows.push_back(row);
    row = '{mk_ray(32'h7FFFFFFF, 0, 0, 32'h80000000, 1, 0, 32'h80000000, 0, 0, 32'h7FFFFFFF),
            0, none}; rows.push_back(row);
    row = '{mk_ray(32'h7FFFFF00, 0, 0, 1 << 24, 0, 0, 32'h7FFFFF00, 0, 0, 32'h7FFFFFFF),
            0, none}; rows.push_back(row);
    row = '{mk_ray(0, 0, 0, -1, -1, -1, 0, 0, 0, 1), 0, none}; rows.push_back(row);
    row = '{mk_ray(1, -1, 0, 32'h7FFFFFFF, 0, 32'h80000000, 0, 0, 0, 1), 0, none};
    rows.push_back(row);
    row = '{mk_ray(-100, 40, 7, 3, -5, 1 << 24, 0, 0, 0, 32'h7FFFFFFF), 0, none};
    rows.push_back(row);
    // tangent-ish graze
    row = '{mk_ray(-4096, 1024, 0, 1 << 24, 0, 0, 0, 0, 0, 1024), 0, none}; rows.push_back(row);

    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].want);
    in_ch.valid <= 1'b0;
    wait (reflect_q.size() == 0);
    @(negedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 6 : (ph == 1) ? 52 : 0;
      recv_idle = (ph == 0) ? 52 : (ph == 1) ? 6 : 0;
      if (ph == 2) hold_req = 1'b1;  // long output stall while rays keep coming
      for (int n = 0; n < 212; n++) send_ray(random_ray(), 0, none);
    end
    in_ch.valid <= 1'b0;

    wait (reflect_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) $display("tb_ray_sphere_reflect_unit: clean");
    else $display("tb_ray_sphere_reflect_unit: errors");
    $finish;
  end

endmodule
